>>> src/cfp_pkg.sv
package cfp_pkg;

  // Sizes
  localparam int PAYLOAD_DEPTH_DEF = 32;
  localparam int RESULT_CAP        = 32;
  localparam int CFG_INDEX_W       = 1;
  localparam int CFG_DATA_W        = 8;

  // Result event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_GOOD  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 1'b1;

  // Reset values and CRC constants
  localparam logic [7:0]  START_BYTE_RST = 8'hAA;
  localparam logic [5:0]  MAX_LENGTH_RST = 6'd32;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  // One request from the parser to the emitter
  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  command;
    logic [5:0]  length;
    logic [31:0] crc_total;
  } cmd_entry_t;

  // Address width of a store of the given depth
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // CRC-16/CCITT-FALSE update over one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> src/cfp_in_if.sv
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/cfp_out_if.sv
interface cfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  command;
  logic [5:0]  length;
  logic [7:0]  data_byte;
  logic [4:0]  data_index;
  logic        last;
  logic [31:0] crc_error_total;

  modport source (output valid, output event_res, output command, output length,
                  output data_byte, output data_index, output last,
                  output crc_error_total, input ready);
  modport sink   (input valid, input event_res, input command, input length,
                  input data_byte, input data_index, input last,
                  input crc_error_total, output ready);
endinterface

>>> src/cfp_ram.sv
module cfp_ram import cfp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic                      re,
  input  logic [addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/cfp_queue.sv
module cfp_queue import cfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output cmd_entry_t head,
  output logic       empty
);

  cmd_entry_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // Store requests in arrival order
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/cfp_front.sv
module cfp_front import cfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  cfp_in_if.sink                            rx,
  output logic                              push,
  output cmd_entry_t                        push_entry,
  input  logic                              q_full,
  input  logic                              frame_done,
  output logic                              ram_we,
  output logic [addr_w(PAYLOAD_DEPTH)-1:0]  ram_waddr,
  output logic [7:0]                        ram_wdata
);

  localparam int AW = addr_w(PAYLOAD_DEPTH);
  localparam logic [5:0] DEPTH_CAP =
    6'((PAYLOAD_DEPTH < RESULT_CAP) ? PAYLOAD_DEPTH : RESULT_CAP);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_CMD    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;
  localparam logic [2:0] PH_CRC_LO = 3'd5;

  logic [7:0]  start_byte;
  logic [5:0]  max_length;
  logic [2:0]  phase;
  logic [5:0]  frame_length;
  logic [7:0]  frame_command;
  logic [5:0]  bytes_received;
  logic [15:0] running_crc;
  logic [7:0]  crc_high_byte;
  logic [31:0] crc_error_count;
  logic        pending;

  logic [7:0]  b;
  logic        take;
  logic [5:0]  acc_max;
  logic        len_bad;
  logic        crc_bad;
  logic        frame_good;
  logic [5:0]  received_next;
  logic [7:0]  received_ext;

  assign b        = rx.rx_byte;
  assign rx.ready = !q_full && !pending;
  assign take     = rx.valid && rx.ready;
  assign acc_max  = (max_length > DEPTH_CAP) ? DEPTH_CAP : max_length;

  // Classify the current byte
  assign len_bad    = (phase == PH_LEN) && (b > {2'b00, acc_max});
  assign crc_bad    = (phase == PH_CRC_LO) && ({crc_high_byte, b} != running_crc);
  assign frame_good = (phase == PH_CRC_LO) && !crc_bad;

  assign received_next = bytes_received + 6'd1;
  assign received_ext  = {2'b00, bytes_received};

  // Build the request for the emitter
  always_comb begin
    push_entry.event_res = EV_NONE;
    push_entry.command   = 8'd0;
    push_entry.length    = 6'd0;
    push_entry.crc_total = crc_error_count + {31'd0, crc_bad};
    if (len_bad || crc_bad) begin
      push_entry.event_res = EV_ERROR;
    end else if (frame_good) begin
      push_entry.event_res = EV_GOOD;
      push_entry.command   = frame_command;
      push_entry.length    = frame_length;
    end
  end

  assign push = take;

  // Payload bytes go to the store
  assign ram_we    = take && (phase == PH_DATA);
  assign ram_waddr = received_ext[AW-1:0];
  assign ram_wdata = b;

  // Configuration, parse state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= START_BYTE_RST;
      max_length      <= MAX_LENGTH_RST;
      phase           <= PH_HUNT;
      frame_length    <= 6'd0;
      frame_command   <= 8'd0;
      bytes_received  <= 6'd0;
      running_crc     <= 16'd0;
      crc_high_byte   <= 8'd0;
      crc_error_count <= 32'd0;
      pending         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_BYTE: start_byte <= cfg_data;
          REG_MAX_LENGTH: max_length <= cfg_data[5:0];
          default:        start_byte <= start_byte;
        endcase
      end

      // Hold the input while the store is being read out
      if (frame_done) begin
        pending <= 1'b0;
      end

      if (take) begin
        unique case (phase)
          PH_LEN: begin
            if (len_bad) begin
              phase <= PH_HUNT;
            end else begin
              frame_length   <= b[5:0];
              bytes_received <= 6'd0;
              running_crc    <= crc_feed(CRC_INIT, b);
              phase          <= PH_CMD;
            end
          end
          PH_CMD: begin
            frame_command <= b;
            running_crc   <= crc_feed(running_crc, b);
            phase         <= (frame_length != 6'd0) ? PH_DATA : PH_CRC_HI;
          end
          PH_DATA: begin
            bytes_received <= received_next;
            running_crc    <= crc_feed(running_crc, b);
            if (received_next >= frame_length) begin
              phase <= PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            crc_high_byte <= b;
            phase         <= PH_CRC_LO;
          end
          PH_CRC_LO: begin
            phase <= PH_HUNT;
            if (crc_bad) begin
              crc_error_count <= crc_error_count + 32'd1;
            end else if (frame_length != 6'd0) begin
              pending <= 1'b1;
            end
          end
          default: begin
            phase <= (b == start_byte) ? PH_LEN : PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

>>> src/cfp_back.sv
module cfp_back import cfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  cmd_entry_t                        q_head,
  output logic                              q_pop,
  output logic                              ram_re,
  output logic [addr_w(PAYLOAD_DEPTH)-1:0]  ram_raddr,
  input  logic [7:0]                        ram_rdata,
  output logic                              frame_done,
  cfp_out_if.source                         res
);

  localparam int AW = addr_w(PAYLOAD_DEPTH);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_SHOW = 1'b1;

  logic        state;
  logic [4:0]  idx;
  logic [7:0]  cur_command;
  logic [5:0]  cur_length;
  logic [31:0] cur_crc_total;

  logic        out_valid;
  logic [1:0]  out_event;
  logic [7:0]  out_command;
  logic [5:0]  out_length;
  logic [7:0]  out_data;
  logic [4:0]  out_index;
  logic        out_last;
  logic [31:0] out_crc_total;

  logic        out_free;
  logic        stream;
  logic        is_last;
  logic [4:0]  idx_next;
  logic [7:0]  idx_next_ext;

  assign out_free     = !out_valid || res.ready;
  assign stream       = (q_head.event_res == EV_GOOD) && (q_head.length != 6'd0);
  assign idx_next     = idx + 5'd1;
  assign idx_next_ext = {3'b000, idx_next};
  assign is_last      = ({1'b0, idx} + 6'd1) == cur_length;

  // Pop requests and fetch payload bytes ahead of the output register
  always_comb begin
    q_pop      = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    frame_done = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop  = 1'b1;
          ram_re = stream;
        end
      end
      B_SHOW: begin
        if (out_free) begin
          if (is_last) begin
            frame_done = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_next_ext[AW-1:0];
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Output register and emitter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      idx       <= 5'd0;
    end else begin
      if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty && out_free) begin
            if (stream) begin
              cur_command   <= q_head.command;
              cur_length    <= q_head.length;
              cur_crc_total <= q_head.crc_total;
              idx           <= 5'd0;
              state         <= B_SHOW;
            end else begin
              out_valid     <= 1'b1;
              out_event     <= q_head.event_res;
              out_command   <= q_head.command;
              out_length    <= q_head.length;
              out_data      <= 8'd0;
              out_index     <= 5'd0;
              out_last      <= 1'b1;
              out_crc_total <= q_head.crc_total;
            end
          end
        end
        B_SHOW: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_event     <= EV_GOOD;
            out_command   <= cur_command;
            out_length    <= cur_length;
            out_data      <= ram_rdata;
            out_index     <= idx;
            out_last      <= is_last;
            out_crc_total <= cur_crc_total;
            if (is_last) begin
              state <= B_IDLE;
            end else begin
              idx <= idx_next;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  assign res.valid           = out_valid;
  assign res.event_res       = out_event;
  assign res.command         = out_command;
  assign res.length          = out_length;
  assign res.data_byte       = out_data;
  assign res.data_index      = out_index;
  assign res.last            = out_last;
  assign res.crc_error_total = out_crc_total;

endmodule

>>> src/crc_checked_frame_parser.sv
// A result passes through the request queue to the output register; the payload of a
// good frame is read from the store, one byte per cycle unless the output stalls.
// Throughput: one byte per cycle while the queue has room; after a good frame with a
// payload the input holds while the payload store is read out.
// Reset (rst, synchronous): parser back to hunting, counters and queue cleared,
// start_byte 0xAA, max_length 32; the payload store is not cleared.
module crc_checked_frame_parser import cfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cfp_in_if.sink                 rx,
  cfp_out_if.source              res
);

  localparam int AW = addr_w(PAYLOAD_DEPTH);

  logic          push;
  cmd_entry_t    push_entry;
  logic          q_full;
  logic          q_pop;
  cmd_entry_t    q_head;
  logic          q_empty;
  logic          frame_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Parser: takes bytes, checks length and CRC
  cfp_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx         (rx),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full),
    .frame_done (frame_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  // Request queue between parser and emitter
  cfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // Payload store
  cfp_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_payload (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Emitter: one result per request or per payload byte
  cfp_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .frame_done (frame_done),
    .res        (res)
  );

endmodule

>>> tb/cfp_tb_pkg.sv
`timescale 1ns / 1ps

package cfp_tb_pkg;
  import cfp_pkg::*;

  // One result as seen on the output channel
  typedef struct {
    logic [1:0]  event_res;
    logic [7:0]  command;
    logic [5:0]  length;
    logic [7:0]  data_byte;
    logic [4:0]  data_index;
    logic        last;
    logic [31:0] crc_total;
  } frame_result_t;

  // Advance a CRC-16/CCITT-FALSE by one byte, one bit at a time, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[15] ^ b[k];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

endpackage

module testbench
  import cfp_pkg::*;
  import cfp_tb_pkg::*;
();

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     chk_fail;
  int                     chk_pending;
  int                     chk_checked;
  int                     bytes_sent;
  int                     frames_sent;
  logic [7:0]             cur_start;

  cfp_in_if  rx_bus ();
  cfp_out_if res_bus ();

  crc_checked_frame_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_bus),
    .res       (res_bus)
  );

  cfp_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx         (rx_bus),
    .res        (res_bus),
    .fail_count (chk_fail),
    .pending    (chk_pending),
    .checked    (chk_checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short idle gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Offer one byte from a falling edge and hold it until accepted
  task automatic send_byte(input logic [7:0] v);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    rx_bus.valid   = 1'b1;
    rx_bus.rx_byte = v;
    @(posedge clk);
    while (!rx_bus.ready) @(posedge clk);
    @(negedge clk);
    rx_bus.valid = 1'b0;
    bytes_sent++;
  endtask

  // Send bytes that never open a frame
  task automatic send_noise(input int count);
    logic [7:0] d;
    for (int i = 0; i < count; i++) begin
      d = 8'($urandom);
      if (d == cur_start) d = d ^ 8'h01;
      send_byte(d);
    end
  endtask

  // Send a whole frame, optionally with a damaged CRC
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  d;
    crc = CRC_INIT;
    send_byte(cur_start);
    send_byte(len);
    crc = crc16_byte(crc, len);
    send_byte(cmd);
    crc = crc16_byte(crc, cmd);
    for (int i = 0; i < int'(len); i++) begin
      d = 8'($urandom);
      send_byte(d);
      crc = crc16_byte(crc, d);
    end
    if (corrupt) crc = crc ^ 16'(1 << $urandom_range(0, 15));
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    frames_sent++;
  endtask

  // Open a frame with a length that must be rejected
  task automatic send_bad_length(input logic [7:0] len);
    send_byte(cur_start);
    send_byte(len);
  endtask

  // Wait until every predicted result has been seen
  task automatic wait_idle();
    @(negedge clk);
    while (chk_pending != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Output side: random ready with gaps
  initial begin
    int gap;
    int burst;
    res_bus.ready = 1'b0;
    forever begin
      gap = pick_gap();
      res_bus.ready = 1'b0;
      repeat (gap) @(negedge clk);
      res_bus.ready = 1'b1;
      burst = $urandom_range(1, 8);
      repeat (burst) @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_START_BYTE;
    cfg_data       = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'd0;
    bytes_sent     = 0;
    frames_sent    = 0;
    cur_start      = START_BYTE_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default registers: noise, edge lengths, a CRC fault, an oversize length, random frames
    send_noise(8);
    send_frame(8'd0, 8'h11, 1'b0);
    send_frame(8'd1, 8'h22, 1'b0);
    send_frame(8'd32, 8'h33, 1'b0);
    send_frame(8'd5, 8'h44, 1'b1);
    send_bad_length(8'd33);
    send_noise(3);
    while (bytes_sent < 170) begin
      send_frame(8'($urandom_range(0, 12)), 8'($urandom), ($urandom_range(0, 3) == 0));
    end

    // Other start byte and a short maximum
    wait_idle();
    write_cfg(REG_START_BYTE, 8'h7E);
    cur_start = 8'h7E;
    write_cfg(REG_MAX_LENGTH, 8'd10);
    send_frame(8'd10, 8'h55, 1'b0);
    send_bad_length(8'd11);
    send_frame(8'd3, 8'h66, 1'b1);

    // A maximum above the store depth saturates to it
    wait_idle();
    write_cfg(REG_START_BYTE, START_BYTE_RST);
    cur_start = START_BYTE_RST;
    write_cfg(REG_MAX_LENGTH, 8'd45);
    send_bad_length(8'd33);
    send_frame(8'd32, 8'h77, 1'b0);
    while (bytes_sent < 262) begin
      send_frame(8'($urandom_range(0, 6)), 8'($urandom), ($urandom_range(0, 3) == 0));
    end
    if (bytes_sent < 270) send_noise(270 - bytes_sent);

    // Drain and give the verdict
    wait_idle();
    repeat (20) @(negedge clk);
    $display("Sent %0d bytes in %0d frames plus noise and oversize lengths, under random stalls;",
             bytes_sent, frames_sent);
    $display("covered empty, single and full-depth payloads, CRC faults and register changes; %0d results compared.",
             chk_checked);
    if (chk_fail == 0 && chk_pending == 0) begin
      $display("crc_checked_frame_parser regression: pass");
    end else begin
      $display("crc_checked_frame_parser regression: fail");
    end
    $finish;
  end

  // Stop a run that never finishes
  initial begin
    #2_000_000;
    $display("run did not finish in time");
    $display("crc_checked_frame_parser regression: fail");
    $finish;
  end

endmodule

>>> tb/cfp_frame_checker.sv
`timescale 1ns / 1ps

module cfp_frame_checker
  import cfp_pkg::*;
  import cfp_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cfp_in_if                      rx,
  cfp_out_if                     res,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  typedef enum logic [2:0] {
    P_HUNT, P_LEN, P_CMD, P_DATA, P_CRC_HI, P_CRC_LO
  } parse_phase_t;

  // Shadow registers and parser state
  logic [7:0]   start_byte;
  logic [5:0]   max_len;
  parse_phase_t phase;
  logic [5:0]   frame_len;
  logic [7:0]   frame_cmd;
  logic [5:0]   bytes_rcvd;
  logic [15:0]  running_crc;
  logic [7:0]   crc_hi;
  logic [7:0]   payload_mem [PAYLOAD_DEPTH_DEF];
  logic [31:0]  crc_err_cnt;

  frame_result_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;
  assign checked    = results_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Largest accepted length: register saturated to the store depth and result cap
  function automatic int length_limit();
    int m;
    m = int'(max_len);
    if (m > PAYLOAD_DEPTH_DEF) m = PAYLOAD_DEPTH_DEF;
    if (m > RESULT_CAP) m = RESULT_CAP;
    return m;
  endfunction

  task automatic push_result(input logic [1:0] ev, input logic [7:0] cmd,
                             input logic [5:0] len, input logic [7:0] data,
                             input logic [4:0] idx, input logic last);
    frame_result_t r;
    r.event_res  = ev;
    r.command    = cmd;
    r.length     = len;
    r.data_byte  = data;
    r.data_index = idx;
    r.last       = last;
    r.crc_total  = crc_err_cnt;
    expected_results.push_back(r);
  endtask

  // Advance the parser by one received byte and queue what it produces
  task automatic predict_byte(input logic [7:0] b);
    logic [15:0] rx_crc;
    int          n;
    case (phase)
      P_LEN: begin
        if (int'(b) > length_limit()) begin
          phase = P_HUNT;
          push_result(EV_ERROR, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1);
        end else begin
          frame_len   = b[5:0];
          bytes_rcvd  = 6'd0;
          running_crc = crc16_byte(CRC_INIT, b);
          phase       = P_CMD;
          push_result(EV_NONE, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1);
        end
      end
      P_CMD: begin
        frame_cmd   = b;
        running_crc = crc16_byte(running_crc, b);
        phase       = (frame_len != 6'd0) ? P_DATA : P_CRC_HI;
        push_result(EV_NONE, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1);
      end
      P_DATA: begin
        if (int'(bytes_rcvd) < PAYLOAD_DEPTH_DEF) payload_mem[int'(bytes_rcvd)] = b;
        bytes_rcvd  = bytes_rcvd + 6'd1;
        running_crc = crc16_byte(running_crc, b);
        if (bytes_rcvd >= frame_len) phase = P_CRC_HI;
        push_result(EV_NONE, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1);
      end
      P_CRC_HI: begin
        crc_hi = b;
        phase  = P_CRC_LO;
        push_result(EV_NONE, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1);
      end
      P_CRC_LO: begin
        rx_crc = {crc_hi, b};
        phase  = P_HUNT;
        if (rx_crc != running_crc) begin
          crc_err_cnt = crc_err_cnt + 32'd1;
          push_result(EV_ERROR, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1);
        end else if (frame_len == 6'd0) begin
          push_result(EV_GOOD, frame_cmd, 6'd0, 8'd0, 5'd0, 1'b1);
        end else begin
          n = (int'(frame_len) > RESULT_CAP) ? RESULT_CAP : int'(frame_len);
          for (int i = 0; i < n; i++) begin
            push_result(EV_GOOD, frame_cmd, frame_len,
                        (i < PAYLOAD_DEPTH_DEF) ? payload_mem[i] : 8'd0,
                        5'(i), (i + 1 == n));
          end
        end
      end
      default: begin
        phase = (b == start_byte) ? P_LEN : P_HUNT;
        push_result(EV_NONE, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1);
      end
    endcase
  endtask

  // Compare one result from the block against the oldest prediction
  task automatic check_result();
    frame_result_t e;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, event %0d", res.event_res));
      return;
    end
    e = expected_results.pop_front();
    if (res.event_res !== e.event_res || res.command !== e.command ||
        res.length !== e.length || res.data_byte !== e.data_byte ||
        res.data_index !== e.data_index || res.last !== e.last ||
        res.crc_error_total !== e.crc_total) begin
      report_mismatch($sformatf(
        "got ev %0d cmd %02h len %0d data %02h idx %0d last %0b total %0d, want ev %0d cmd %02h len %0d data %02h idx %0d last %0b total %0d",
        res.event_res, res.command, res.length, res.data_byte, res.data_index,
        res.last, res.crc_error_total, e.event_res, e.command, e.length,
        e.data_byte, e.data_index, e.last, e.crc_total));
    end
  endtask

  // Watch both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      start_byte  = START_BYTE_RST;
      max_len     = MAX_LENGTH_RST;
      phase       = P_HUNT;
      frame_len   = 6'd0;
      frame_cmd   = 8'd0;
      bytes_rcvd  = 6'd0;
      running_crc = 16'd0;
      crc_hi      = 8'd0;
      crc_err_cnt = 32'd0;
      expected_results.delete();
      queued = 0;
    end else begin
      if (res.valid && res.ready) begin
        check_result();
      end
      if (rx.valid && rx.ready) begin
        predict_byte(rx.rx_byte);
      end
      if (cfg_we) begin
        if (cfg_index == REG_START_BYTE) start_byte = cfg_data;
        else if (cfg_index == REG_MAX_LENGTH) max_len = cfg_data[5:0];
      end
      queued = expected_results.size();
    end
  end

endmodule

>>> crc_checked_frame_parser.f
src/cfp_pkg.sv
src/cfp_in_if.sv
src/cfp_out_if.sv
src/cfp_ram.sv
src/cfp_queue.sv
src/cfp_front.sv
src/cfp_back.sv
src/crc_checked_frame_parser.sv
tb/cfp_tb_pkg.sv
tb/cfp_frame_checker.sv
